FILE: hw/rtl/polyline_distance_decimator_assert.svh
// Assertion macros for the polyline decimator
`ifndef POLYLINE_DISTANCE_DECIMATOR_ASSERT_SVH
`define POLYLINE_DISTANCE_DECIMATOR_ASSERT_SVH

// Antecedent implies consequent on the next cycle
`define PDD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

// Condition always holds outside reset
`define PDD_ASSERT_ALWAYS(label, clk, rst, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

`endif

FILE: hw/rtl/pdd_pkg.sv
`default_nettype none
package pdd_pkg;
  localparam int LatW = 28;
  localparam int LonW = 29;
  localparam int CntW = 20;
  localparam int DistW = 32;
  localparam int MinW = 24;
  localparam int CordicSteps = 16;
  localparam int TableLen = 24;
  localparam int StepN = (CordicSteps < TableLen) ? CordicSteps : TableLen;
  localparam int StepW = $clog2(StepN + 1);
  // CORDIC datapath width: values stay well under 2^33
  localparam int CW = 36;
  localparam logic signed [CW-1:0] GainQ30 = 36'sd652032874;
  localparam logic signed [CW-1:0] OneQ30 = 36'sd1073741824;
  localparam logic [LatW-1:0] Deg90 = 28'd94371840;
  localparam logic [31:0] KmPerUnitQ32 = 32'd116723985;
  localparam logic [CntW-1:0] CountMax = '1;

  typedef struct packed {
    logic signed [LatW-1:0] lat;
    logic signed [LonW-1:0] lon;
    logic first;
    logic last;
  } point_t;

  // Queue entry: the point plus the previous point it is measured from
  typedef struct packed {
    point_t pt;
    logic signed [LatW-1:0] plat;
    logic signed [LonW-1:0] plon;
  } job_t;

  function automatic logic signed [CW-1:0] atan_deg20(input logic [4:0] i);
    case (i)
      5'd0: atan_deg20 = 36'sd47185920;
      5'd1: atan_deg20 = 36'sd27855475;
      5'd2: atan_deg20 = 36'sd14718068;
      5'd3: atan_deg20 = 36'sd7471121;
      5'd4: atan_deg20 = 36'sd3750058;
      5'd5: atan_deg20 = 36'sd1876857;
      5'd6: atan_deg20 = 36'sd938658;
      5'd7: atan_deg20 = 36'sd469357;
      5'd8: atan_deg20 = 36'sd234682;
      5'd9: atan_deg20 = 36'sd117342;
      5'd10: atan_deg20 = 36'sd58671;
      5'd11: atan_deg20 = 36'sd29335;
      5'd12: atan_deg20 = 36'sd14668;
      5'd13: atan_deg20 = 36'sd7334;
      5'd14: atan_deg20 = 36'sd3667;
      5'd15: atan_deg20 = 36'sd1833;
      5'd16: atan_deg20 = 36'sd917;
      5'd17: atan_deg20 = 36'sd458;
      5'd18: atan_deg20 = 36'sd229;
      5'd19: atan_deg20 = 36'sd115;
      5'd20: atan_deg20 = 36'sd57;
      5'd21: atan_deg20 = 36'sd29;
      5'd22: atan_deg20 = 36'sd14;
      5'd23: atan_deg20 = 36'sd7;
      default: atan_deg20 = '0;
    endcase
  endfunction
endpackage
`default_nettype wire

FILE: hw/rtl/pdd_front.sv
`default_nettype none
module pdd_front (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  output logic in_ready,
  input  wire pdd_pkg::point_t in_pt,
  output logic q_valid,
  input  wire logic q_ready,
  output pdd_pkg::job_t q_job
);
  import pdd_pkg::*;

  // two-entry queue; front tracks the previous point
  job_t mem [2];
  logic wp, rp;
  logic [1:0] cnt;
  logic signed [LatW-1:0] plat;
  logic signed [LonW-1:0] plon;
  logic push, pop;

  assign in_ready = !rst && (cnt != 2'd2);
  assign push = in_valid && in_ready;
  assign q_valid = (cnt != 2'd0);
  assign pop = q_valid && q_ready;
  assign q_job = mem[rp];

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= 1'b0;
      rp <= 1'b0;
      cnt <= 2'd0;
      plat <= '0;
      plon <= '0;
    end else begin
      if (push) begin
        mem[wp] <= '{pt: in_pt, plat: plat, plon: plon};
        wp <= ~wp;
        plat <= in_pt.lat;
        plon <= in_pt.lon;
      end
      if (pop) rp <= ~rp;
      cnt <= cnt + {1'b0, push} - {1'b0, pop};
    end
  end
endmodule
`default_nettype wire

FILE: hw/rtl/pdd_back.sv
`default_nettype none
module pdd_back (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic [pdd_pkg::MinW-1:0] min_distance,
  input  wire logic q_valid,
  output logic q_ready,
  input  wire pdd_pkg::job_t q_job,
  output logic out_valid,
  input  wire logic out_ready,
  output logic signed [pdd_pkg::LatW-1:0] out_lat,
  output logic signed [pdd_pkg::LonW-1:0] out_lon,
  output logic out_end,
  output logic [pdd_pkg::CntW-1:0] out_total
);
  import pdd_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_SCALE_A, S_SCALE_B, S_COS, S_MULC, S_HYP, S_GAIN, S_ACC, S_DECIDE, S_OUT
  } state_t;

  state_t state;
  job_t job;
  logic [StepW-1:0] step;
  logic signed [CW-1:0] x, y, z;
  logic [LatW:0] dlat;
  logic [LonW:0] dlon;
  logic [35:0] dy, dx;
  logic [DistW-1:0] acc;
  logic [DistW-1:0] leg;
  logic [CntW-1:0] kcnt;
  logic [63:0] prod;
  logic [69:0] gprod;
  logic signed [CW-1:0] xs, ys, atn, xc;
  logic signed [LatW:0] dl_s;
  logic signed [LonW:0] dn_s;
  logic [LatW-1:0] alat;
  logic [DistW:0] sum;

  assign q_ready = (state == S_IDLE);
  assign xs = x >>> step;
  assign ys = y >>> step;
  assign atn = atan_deg20(5'(step));
  assign dl_s = {job.pt.lat[LatW-1], job.pt.lat} - {job.plat[LatW-1], job.plat};
  assign dn_s = {job.pt.lon[LonW-1], job.pt.lon} - {job.plon[LonW-1], job.plon};
  assign alat = job.plat[LatW-1] ? LatW'(-job.plat) : job.plat;
  assign xc = x[CW-1] ? '0 : ((x > OneQ30) ? OneQ30 : x);
  assign sum = {1'b0, acc} + {1'b0, leg};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      acc <= '0;
      kcnt <= '0;
      out_valid <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: if (q_valid) begin
          job <= q_job;
          state <= q_job.pt.first ? S_DECIDE : S_SCALE_A;
        end
        S_SCALE_A: begin
          dlat <= dl_s[LatW] ? (LatW+1)'(-dl_s) : (LatW+1)'(dl_s);
          dlon <= dn_s[LonW] ? (LonW+1)'(-dn_s) : (LonW+1)'(dn_s);
          state <= S_SCALE_B;
        end
        S_SCALE_B: begin
          prod <= 64'(dlat) * 64'(KmPerUnitQ32);
          dx <= 36'((64'(dlon) * 64'(KmPerUnitQ32)) >> 32);
          x <= GainQ30;
          y <= '0;
          z <= CW'((alat > Deg90) ? Deg90 : alat);
          step <= '0;
          state <= S_COS;
        end
        S_COS: begin
          if (step == 0) dy <= 36'(prod >> 32);
          if (!z[CW-1]) begin
            x <= x - ys; y <= y + xs; z <= z - atn;
          end else begin
            x <= x + ys; y <= y - xs; z <= z + atn;
          end
          step <= step + 1'b1;
          if (step == StepW'(StepN - 1)) state <= S_MULC;
        end
        S_MULC: begin
          x <= CW'((72'(dx) * 72'(xc)) >> 30);
          y <= $signed(dy);
          step <= '0;
          state <= S_HYP;
        end
        S_HYP: begin
          if (!y[CW-1]) begin
            x <= x + ys; y <= y - xs;
          end else begin
            x <= x - ys; y <= y + xs;
          end
          step <= step + 1'b1;
          if (step == StepW'(StepN - 1)) state <= S_GAIN;
        end
        S_GAIN: begin
          gprod <= 70'($signed(70'(x)) * $signed(70'(GainQ30)));
          state <= S_ACC;
        end
        S_ACC: begin
          leg <= gprod[69] ? '0 : DistW'(gprod >> 30);
          state <= S_DECIDE;
        end
        S_DECIDE: begin
          if (job.pt.first) begin
            acc <= '0;
            kcnt <= CntW'(1);
            state <= S_OUT;
          end else begin
            if (sum[DistW] ? 1'b1 : (sum[DistW-1:0] > DistW'(min_distance))
                || job.pt.last) begin
              acc <= '0;
              if (kcnt != CountMax) kcnt <= kcnt + 1'b1;
              state <= S_OUT;
            end else begin
              acc <= sum[DistW] ? '1 : sum[DistW-1:0];
              state <= S_IDLE;
            end
          end
        end
        S_OUT: if (!out_valid) begin
          out_valid <= 1'b1;
          out_lat <= job.pt.lat;
          out_lon <= job.pt.lon;
          out_end <= job.pt.last;
          out_total <= kcnt;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
      if (out_valid && out_ready) out_valid <= 1'b0;
      if (state == S_SCALE_B) leg <= '0;
    end
  end
endmodule
`default_nettype wire

FILE: hw/rtl/polyline_distance_decimator.sv
// Each point runs two 16-step CORDIC passes on one shared unit.
// The back end takes a new point only when it is done with the last; first points skip the CORDIC passes.
// A two-word queue parts input from the CORDIC back end; output is registered.
// Reset (rst, synchronous): min_distance 512, state and counters cleared.
`default_nettype none
`include "polyline_distance_decimator_assert.svh"
module polyline_distance_decimator (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic psel,
  input  wire logic penable,
  input  wire logic pwrite,
  input  wire logic [1:0] paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic pready,
  input  wire logic s_tvalid,
  output logic s_tready,
  input  wire logic [63:0] s_tdata, // latitude[27:0], longitude[56:28]
  input  wire logic s_tlast,        // last_point
  input  wire logic s_tuser,        // first_point
  output logic m_tvalid,
  input  wire logic m_tready,
  output logic [79:0] m_tdata,      // kept_latitude[27:0], kept_longitude[56:28], kept_total[76:57]
  output logic m_tlast              // line_end
);
  import pdd_pkg::*;

  localparam logic [1:0] RegMinDist = 2'd0;

  logic [MinW-1:0] min_distance;
  point_t in_pt;
  job_t q_job;
  logic q_valid, q_ready;
  logic signed [LatW-1:0] o_lat;
  logic signed [LonW-1:0] o_lon;
  logic [CntW-1:0] o_tot;

  assign pready = 1'b1;
  assign prdata = (paddr == RegMinDist) ? {8'd0, min_distance} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) min_distance <= MinW'(512);
    else if (psel && penable && pwrite && paddr == RegMinDist) min_distance <= pwdata[MinW-1:0];
  end

  assign in_pt = '{lat: s_tdata[27:0], lon: s_tdata[56:28], first: s_tuser, last: s_tlast};

  pdd_front u_front (
    .clk, .rst, .in_valid(s_tvalid), .in_ready(s_tready), .in_pt,
    .q_valid, .q_ready, .q_job
  );

  pdd_back u_back (
    .clk, .rst, .min_distance, .q_valid, .q_ready, .q_job,
    .out_valid(m_tvalid), .out_ready(m_tready), .out_lat(o_lat), .out_lon(o_lon),
    .out_end(m_tlast), .out_total(o_tot)
  );

  assign m_tdata = {3'd0, o_tot, o_lon, o_lat};

  `PDD_ASSERT_NEXT(a_out_hold, clk, rst, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "output word dropped")
  `PDD_ASSERT_ALWAYS(a_total_nz, clk, rst, !m_tvalid || (o_tot != '0), "kept total zero on output")
  `PDD_ASSERT_NEXT(a_q_stall, clk, rst, q_valid && !q_ready, q_valid, "queue lost entry")
endmodule
`default_nettype wire

FILE: tb/sv/polyline_distance_decimator_test.sv
`default_nettype none
module polyline_distance_decimator_test;
  timeunit 1ns;
  timeprecision 1ps;
  import pdd_pkg::*;

  localparam logic [1:0] RegMinDistance = 2'd0;
  localparam int LatMax = 94371840;
  localparam int LonMax = 188743680;
  localparam int CycleLimit = 2000000;

  typedef struct packed {
    logic signed [LatW-1:0] lat;
    logic signed [LonW-1:0] lon;
    logic line_end;
    logic [CntW-1:0] total;
  } kept_t;

  class kept_point_board;
    logic [MinW-1:0] min_dist;
    logic signed [LatW-1:0] prev_lat;
    logic signed [LonW-1:0] prev_lon;
    logic [DistW-1:0] acc;
    logic [CntW-1:0] count;
    kept_t pending[$];
    int errors;
    longint atan_tab[24];

    function new();
      atan_tab = '{47185920, 27855475, 14718068, 7471121, 3750058, 1876857, 938658,
                   469357, 234682, 117342, 58671, 29335, 14668, 7334, 3667, 1833,
                   917, 458, 229, 115, 57, 29, 14, 7};
      min_dist = 512;
      prev_lat = '0;
      prev_lon = '0;
      acc = '0;
      count = '0;
      errors = 0;
    endfunction

    // arithmetic >>> on longint is a floor shift
    function longint cos_fix(longint lat);
      longint x, y, z, xs, ys;
      x = 652032874;
      y = 0;
      z = lat < 0 ? -lat : lat;
      if (z > LatMax) z = LatMax;
      for (int i = 0; i < StepN; i++) begin
        xs = x >>> i;
        ys = y >>> i;
        if (z >= 0) begin
          x -= ys; y += xs; z -= atan_tab[i];
        end else begin
          x += ys; y -= xs; z += atan_tab[i];
        end
      end
      if (x < 0) x = 0;
      if (x > 64'sd1073741824) x = 64'sd1073741824;
      return x;
    endfunction

    function longint leg_len(longint lat, longint lon);
      longint dlat, dlon, dx, dy, x, y, xs, ys;
      dlat = lat - longint'(prev_lat);
      dlon = lon - longint'(prev_lon);
      if (dlat < 0) dlat = -dlat;
      if (dlon < 0) dlon = -dlon;
      dy = (dlat * 116723985) >>> 32;
      dx = (dlon * 116723985) >>> 32;
      dx = (dx * cos_fix(longint'(prev_lat))) >>> 30;
      x = dx;
      y = dy;
      for (int i = 0; i < StepN; i++) begin
        xs = x >>> i;
        ys = y >>> i;
        if (y >= 0) begin
          x += ys; y -= xs;
        end else begin
          x -= ys; y += xs;
        end
      end
      x = (x * 652032874) >>> 30;
      return x < 0 ? 0 : x;
    endfunction

    function void note_point(point_t p);
      logic keep;
      longint sum;
      kept_t k;
      if (p.first) begin
        acc = '0;
        count = '0;
        keep = 1'b1;
      end else begin
        sum = longint'(acc) + leg_len(longint'(p.lat), longint'(p.lon));
        if (sum > 64'hFFFFFFFF) sum = 64'hFFFFFFFF;
        acc = sum[31:0];
        keep = p.last || (acc > {8'd0, min_dist});
      end
      prev_lat = p.lat;
      prev_lon = p.lon;
      if (keep) begin
        acc = '0;
        if (count != CountMax) count++;
        k.lat = p.lat;
        k.lon = p.lon;
        k.line_end = p.last;
        k.total = count;
        pending.push_back(k);
      end
    endfunction

    function void check_kept(kept_t got);
      kept_t exp;
      if (pending.size() == 0) begin
        $error("unexpected word: lat %0d lon %0d", got.lat, got.lon);
        errors++;
        return;
      end
      exp = pending.pop_front();
      if (got.lat !== exp.lat) begin
        $error("kept_latitude exp %0d got %0d", exp.lat, got.lat); errors++;
      end
      if (got.lon !== exp.lon) begin
        $error("kept_longitude exp %0d got %0d", exp.lon, got.lon); errors++;
      end
      if (got.line_end !== exp.line_end) begin
        $error("line_end exp %0d got %0d", exp.line_end, got.line_end); errors++;
      end
      if (got.total !== exp.total) begin
        $error("kept_total exp %0d got %0d", exp.total, got.total); errors++;
      end
    endfunction
  endclass

  logic clk, rst;
  logic psel, penable, pwrite;
  logic [1:0] paddr;
  logic [31:0] pwdata, prdata;
  logic pready;
  logic s_tvalid, s_tready, s_tlast, s_tuser;
  logic [63:0] s_tdata;
  logic m_tvalid, m_tready, m_tlast;
  logic [79:0] m_tdata;

  kept_point_board board;
  bit idle_en;
  bit hold_off;
  int cycles;

  polyline_distance_decimator u_dut (
    .clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .s_tvalid, .s_tready, .s_tdata, .s_tlast, .s_tuser,
    .m_tvalid, .m_tready, .m_tdata, .m_tlast
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > CycleLimit) begin
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  // receiver: random stalls, plus a long hold-off on request
  initial begin
    kept_t got;
    m_tready = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && m_tvalid && m_tready) begin
        got = {m_tdata[27:0], m_tdata[56:28], m_tlast, m_tdata[76:57]};
        board.check_kept(got);
      end
      m_tready <= !hold_off && !(idle_en && $urandom_range(99) < 22);
    end
  end

  task automatic write_reg(input logic [1:0] addr, input logic [31:0] val);
    psel <= 1'b1; pwrite <= 1'b1; paddr <= addr; pwdata <= val; penable <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    if (addr == RegMinDistance) board.min_dist = val[MinW-1:0];
  endtask

  task automatic send_point(input int lat, input int lon, input bit first, input bit last);
    point_t p;
    p.lat = LatW'(lat);
    p.lon = LonW'(lon);
    p.first = first;
    p.last = last;
    while (idle_en && $urandom_range(99) < 22) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {7'd0, p.lon, p.lat};
    s_tlast <= last;
    s_tuser <= first;
    do @(posedge clk); while (!s_tready);
    board.note_point(p);
  endtask

  // dropped points still in the queue or the back end must finish before the next phase
  task automatic drain();
    s_tvalid <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
  endtask

  function automatic int rand_lat();
    return int'($urandom_range(2 * LatMax)) - LatMax;
  endfunction

  function automatic int rand_lon();
    return int'($urandom_range(2 * LonMax)) - LonMax;
  endfunction

  // well-formed polyline with short random legs around a random start
  task automatic send_line(input int len, input int step);
    int lat, lon;
    lat = rand_lat();
    lon = rand_lon();
    for (int i = 0; i < len; i++) begin
      send_point(lat, lon, i == 0, i == len - 1);
      lat += int'($urandom_range(2 * step)) - step;
      lon += int'($urandom_range(2 * step)) - step;
      if (lat > LatMax) lat = LatMax;
      if (lat < -LatMax) lat = -LatMax;
      if (lon > LonMax) lon = LonMax;
      if (lon < -LonMax) lon = -LonMax;
    end
  endtask

  initial begin
    int sent, lim[4];
    board = new();
    idle_en = 1'b0;
    hold_off = 1'b0;
    rst = 1'b1;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    s_tvalid = 1'b0; s_tdata = '0; s_tlast = 1'b0; s_tuser = 1'b0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: missing first mark from reset origin, extremes, poles, wrap
    send_point(1000, 2000, 0, 0);
    send_point(LatMax, LonMax, 0, 0);
    send_point(-LatMax, -LonMax, 0, 0);
    send_point(LatMax, LonMax, 1, 1);
    send_point(-LatMax, 0, 1, 0);
    send_point(-LatMax, 100000, 0, 0);
    send_point(0, LonMax, 0, 0);
    send_point(0, -LonMax, 0, 0);
    send_point(5, 5, 0, 1);
    send_point(-(1 << 27), -(1 << 28), 0, 0);
    send_point((1 << 27) - 1, (1 << 28) - 1, 0, 0);
    send_point(0, 0, 1, 0);
    send_point(1, 1, 0, 0);
    send_point(2, 2, 0, 0);
    send_point(3, 3, 0, 1);
    drain();

    write_reg(RegMinDistance, 32'h00FFFFFF);
    send_point(0, 0, 1, 0);
    send_point(LatMax, LonMax, 0, 0);
    send_point(-LatMax, -LonMax, 0, 0);
    send_point(0, 0, 0, 1);
    drain();

    idle_en = 1'b1;
    lim = '{1, 512, 40000, 24'hFFFFFF};
    sent = 0;
    for (int ph = 0; ph < 4; ph++) begin
      write_reg(RegMinDistance, lim[ph]);
      while (sent < (ph + 1) * 380) begin
        if ($urandom_range(9) == 0) begin
          send_point(rand_lat(), rand_lon(), 1'($urandom_range(1)), 1'($urandom_range(1)));
          sent++;
        end else begin
          int len;
          len = $urandom_range(1, 12);
          send_line(len, (ph == 3) ? 4000000 : 20000);
          sent += len;
        end
        if (ph == 1 && sent > 500 && sent < 520) begin
          idle_en = 1'b0;
          hold_off = 1'b1;
          fork
            begin
              repeat (800) @(posedge clk);
              hold_off = 1'b0;
            end
          join_none
          send_line(30, 20000);
          sent += 30;
          idle_en = 1'b1;
        end
      end
      drain();
    end
    write_reg(RegMinDistance, 512);

    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule
`default_nettype wire

FILE: files.f
+incdir+hw/rtl
hw/rtl/pdd_pkg.sv
hw/rtl/pdd_front.sv
hw/rtl/pdd_back.sv
hw/rtl/polyline_distance_decimator.sv
tb/sv/polyline_distance_decimator_test.sv
